FILE: rtl/core/sccad_pkg.sv
// shared types, constants and saturating helpers for the sinh/cosh block
// no dependencies
`default_nettype none

package sccad_pkg;

  localparam int MAX_HALVINGS_DEF = 32;
  localparam int FRAC_BITS_DEF    = 28;

  localparam int ANGLE_W  = 31;
  localparam int SINH_W   = 35;
  localparam int COSH_W   = 34;
  localparam int TOL_W    = 29;
  localparam int WORK_W   = 63;
  localparam int WORK_FRAC = 58;
  localparam int PROD_W   = 2 * WORK_W;
  localparam int XW       = 73;
  localparam int DIV_W    = 64;
  localparam int DIV_STEPS = DIV_W / 2;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(268);

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [SINH_W-1:0]  sinh_t;
  typedef logic        [COSH_W-1:0]  cosh_t;
  typedef logic        [TOL_W-1:0]   tol_t;
  typedef logic        [WORK_W-1:0]  work_t;

  localparam work_t WORK_ONE = work_t'(1) << WORK_FRAC;

  typedef struct packed {
    logic  start;
    work_t a;
    work_t b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    work_t res;
  } mul_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HALVE,
    ST_Y2,
    ST_Y3,
    ST_DIV,
    ST_SEED,
    ST_DBL_T,
    ST_DBL_U,
    ST_OUT
  } state_e;

  function automatic work_t sat_add(work_t a, work_t b);
    logic [WORK_W:0] r;
    r = {1'b0, a} + {1'b0, b};
    return r[WORK_W] ? '1 : r[WORK_W-1:0];
  endfunction

  function automatic work_t sat_dbl(work_t a);
    return a[WORK_W-1] ? '1 : {a[WORK_W-2:0], 1'b0};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sccad_if.sv
// request channels for the angle input and the sinh/cosh result
// depends on sccad_pkg
`default_nettype none

interface sccad_in_if;
  import sccad_pkg::*;
  logic   valid;
  logic   ready;
  angle_t angle;
  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface sccad_out_if;
  import sccad_pkg::*;
  logic  valid;
  logic  ready;
  sinh_t sinh_value;
  cosh_t cosh_value;
  modport source (output valid, output sinh_value, output cosh_value, input ready);
  modport sink   (input valid, input sinh_value, input cosh_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sinh_cosh_by_angle_doubling.sv
// top level: tolerance register, sequencer core and shared multiplier
// depends on sccad_pkg, sccad_if, sccad_mul and sccad_core
`default_nettype none

// Returns sinh and cosh of a signed fixed-point angle (FRAC_BITS fraction
// bits) by halving the angle k times until its magnitude drops below the
// tolerance register, seeding with short series and doubling k times. One
// request is worked on at a time: halving count, series products, divide
// by six, doubling steps, each product on the single 32x32 multiplier,
// which builds a 63x63 product from four partial products; two products
// per doubling step. k is at most MAX_HALVINGS. The result waits in an
// output register, and the next request is taken while it waits. The
// user must write the tolerance through cfg_we_i/cfg_wdata_i only while
// the block is idle, which the block does not enforce; reset value 268.

module sinh_cosh_by_angle_doubling #(
  parameter int MAX_HALVINGS = sccad_pkg::MAX_HALVINGS_DEF,
  parameter int FRAC_BITS    = sccad_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  sccad_pkg::tol_t cfg_wdata_i,
  sccad_in_if.sink        in_i,
  sccad_out_if.source     out_o
);
  import sccad_pkg::*;

  tol_t     tol_q;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  sccad_core #(
    .MAX_HALVINGS (MAX_HALVINGS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tol_i     (tol_q),
    .in_i      (in_i),
    .out_o     (out_o),
    .mul_req_o (mul_req),
    .mul_rsp_i (mul_rsp)
  );

  sccad_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

endmodule

`default_nettype wire

FILE: rtl/core/sccad_mul.sv
// shared 63x63 fractional multiplier, four 32x32 partial products over cycles
// depends on sccad_pkg; result truncated to 58 fraction bits and saturated
`default_nettype none

module sccad_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sccad_pkg::mul_req_t req_i,
  output sccad_pkg::mul_rsp_t rsp_o
);
  import sccad_pkg::*;

  work_t              a_q, b_q;
  logic [2:0]         cnt_q;
  logic               busy_q, pvld_q, done_q;
  logic [1:0]         psel_q;
  logic [63:0]        pp_q;
  logic [PROD_W-1:0]  acc_q;
  logic [31:0]        opa, opb;
  logic [PROD_W-1:0]  addend;

  assign opa = cnt_q[0] ? {1'b0, a_q[WORK_W-1:32]} : a_q[31:0];
  assign opb = cnt_q[1] ? {1'b0, b_q[WORK_W-1:32]} : b_q[31:0];

  always_comb begin
    case (psel_q)
      2'd0:    addend = PROD_W'(pp_q);
      2'd3:    addend = PROD_W'(pp_q) << 64;
      default: addend = PROD_W'(pp_q) << 32;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pvld_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      pvld_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q  <= cnt_q + 3'd1;
      pvld_q <= (cnt_q != 3'd4);
      if (cnt_q == 3'd4) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q != 3'd4) begin
        pp_q   <= opa * opb;
        psel_q <= cnt_q[1:0];
      end
      if (pvld_q) begin
        acc_q <= acc_q + addend;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = (|acc_q[PROD_W-1:WORK_FRAC+WORK_W]) ? '1
                                                          : acc_q[WORK_FRAC+WORK_W-1:WORK_FRAC];

endmodule

`default_nettype wire

FILE: rtl/core/sccad_core.sv
// sequencer and datapath: halving count, series seed, divide by six,
// doubling steps and output rounding; depends on sccad_pkg and sccad_if
`default_nettype none

module sccad_core #(
  parameter int MAX_HALVINGS = sccad_pkg::MAX_HALVINGS_DEF,
  parameter int FRAC_BITS    = sccad_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sccad_pkg::tol_t     tol_i,
  sccad_in_if.sink            in_i,
  sccad_out_if.source         out_o,
  output sccad_pkg::mul_req_t mul_req_o,
  input  sccad_pkg::mul_rsp_t mul_rsp_i
);
  import sccad_pkg::*;

  localparam int UP  = WORK_FRAC - FRAC_BITS;
  localparam int KW  = $clog2(MAX_HALVINGS + 1);
  localparam int DCW = $clog2(DIV_STEPS);

  state_e                 state_q, state_d;
  logic                   issued_q;
  logic [KW-1:0]          k_q;
  logic [ANGLE_W-1:0]     m_q;
  work_t                  y_q, y2_q, s_q, c_q, t_q;
  logic                   neg_q;
  logic [DIV_W-1:0]       dv_q;
  logic [2:0]             rem_q;
  logic [DCW-1:0]         dcnt_q;
  logic                   ov_q;
  sinh_t                  os_q;
  cosh_t                  oc_q;

  logic                   in_acc, out_free, halve_go, mul_state;
  logic [ANGLE_W-1:0]     raw, mag;
  logic [XW-1:0]          xw;
  work_t                  x0;
  logic [4:0]             dv5;
  logic [1:0]             qd;
  logic [2:0]             rem_d;
  logic [WORK_W:0]        s_r, c_r;
  logic [COSH_W-1:0]      s_o, c_o;
  logic [SINH_W-1:0]      s_ext;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !ov_q || out_o.ready;
  assign halve_go = (k_q < KW'(MAX_HALVINGS)) && !(m_q < ANGLE_W'(tol_i));

  assign raw = in_i.angle;
  assign mag = raw[ANGLE_W-1] ? (~raw + ANGLE_W'(1)) : raw;
  assign xw  = XW'(mag) << UP;
  assign x0  = (|xw[XW-1:WORK_W]) ? '1 : xw[WORK_W-1:0];

  // radix-4 digit of the divide by six
  assign dv5 = {rem_q[1:0], dv_q[DIV_W-1:DIV_W-2]} + {rem_q[2], 4'b0};
  always_comb begin
    if (dv5 >= 5'd18) begin
      qd = 2'd3; rem_d = 3'(dv5 - 5'd18);
    end else if (dv5 >= 5'd12) begin
      qd = 2'd2; rem_d = 3'(dv5 - 5'd12);
    end else if (dv5 >= 5'd6) begin
      qd = 2'd1; rem_d = 3'(dv5 - 5'd6);
    end else begin
      qd = 2'd0; rem_d = dv5[2:0];
    end
  end

  // round half up, then saturate magnitude
  assign s_r   = {1'b0, s_q >> UP} + (WORK_W + 1)'(s_q[UP-1]);
  assign c_r   = {1'b0, c_q >> UP} + (WORK_W + 1)'(c_q[UP-1]);
  assign s_o   = (|s_r[WORK_W:COSH_W]) ? '1 : s_r[COSH_W-1:0];
  assign c_o   = (|c_r[WORK_W:COSH_W]) ? '1 : c_r[COSH_W-1:0];
  assign s_ext = neg_q ? (~{1'b0, s_o} + SINH_W'(1)) : {1'b0, s_o};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_HALVE;
      ST_HALVE: if (!halve_go) state_d = ST_Y2;
      ST_Y2:    if (mul_rsp_i.done) state_d = ST_Y3;
      ST_Y3:    if (mul_rsp_i.done) state_d = ST_DIV;
      ST_DIV:   if (dcnt_q == '1) state_d = ST_SEED;
      ST_SEED:  state_d = (k_q == '0) ? ST_OUT : ST_DBL_T;
      ST_DBL_T: if (mul_rsp_i.done) state_d = ST_DBL_U;
      ST_DBL_U: if (mul_rsp_i.done) state_d = (k_q == KW'(1)) ? ST_OUT : ST_DBL_T;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_state     = 1'b0;
    mul_req_o.a   = s_q;
    mul_req_o.b   = s_q;
    case (state_q)
      ST_Y2: begin
        mul_state   = 1'b1;
        mul_req_o.a = y_q;
        mul_req_o.b = y_q;
      end
      ST_Y3: begin
        mul_state   = 1'b1;
        mul_req_o.a = y2_q;
        mul_req_o.b = y_q;
      end
      ST_DBL_T: begin
        mul_state   = 1'b1;
        mul_req_o.b = c_q;
      end
      ST_DBL_U: mul_state = 1'b1;
      default:  mul_state = 1'b0;
    endcase
    mul_req_o.start = mul_state && !issued_q;
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = ov_q;
  assign out_o.sinh_value = os_q;
  assign out_o.cosh_value = oc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      ov_q     <= 1'b0;
      k_q      <= '0;
      dcnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (mul_req_o.start) begin
        issued_q <= 1'b1;
      end else if (mul_rsp_i.done) begin
        issued_q <= 1'b0;
      end
      if (state_q == ST_OUT && out_free) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE:  k_q <= '0;
        ST_HALVE: if (halve_go) k_q <= k_q + KW'(1);
        ST_DBL_U: if (mul_rsp_i.done) k_q <= k_q - KW'(1);
        default:  k_q <= k_q;
      endcase
      if (state_q == ST_DIV) begin
        dcnt_q <= dcnt_q + DCW'(1);
      end else begin
        dcnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        m_q   <= mag;
        y_q   <= x0;
        neg_q <= raw[ANGLE_W-1];
      end
      ST_HALVE: begin
        if (halve_go) begin
          m_q <= m_q >> 1;
          y_q <= y_q >> 1;
        end
      end
      ST_Y2: begin
        if (mul_rsp_i.done) begin
          y2_q <= mul_rsp_i.res;
          c_q  <= sat_add(WORK_ONE, mul_rsp_i.res >> 1);
        end
      end
      ST_Y3: begin
        if (mul_rsp_i.done) begin
          dv_q  <= DIV_W'(mul_rsp_i.res);
          rem_q <= '0;
        end
      end
      ST_DIV: begin
        dv_q  <= {dv_q[DIV_W-3:0], qd};
        rem_q <= rem_d;
      end
      ST_SEED:  s_q <= sat_add(y_q, dv_q[WORK_W-1:0]);
      ST_DBL_T: if (mul_rsp_i.done) t_q <= mul_rsp_i.res;
      ST_DBL_U: begin
        if (mul_rsp_i.done) begin
          s_q <= sat_dbl(t_q);
          c_q <= sat_add(WORK_ONE, sat_dbl(mul_rsp_i.res));
        end
      end
      ST_OUT: begin
        if (out_free) begin
          os_q <= s_ext;
          oc_q <= c_o;
        end
      end
      default: begin
        m_q <= m_q;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: tb/sinh_cosh_checker.sv
// checker for the sinh/cosh block: watches both request channels and the tolerance port,
// predicts each result and compares it field by field
// depends on sccad_pkg and sccad_if
`default_nettype none

module sinh_cosh_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  sccad_pkg::tol_t cfg_wdata_i,
  sccad_in_if             in_mon_i,
  sccad_out_if            out_mon_i,
  output int              fail_count_o,
  output int              pending_o
);
  import sccad_pkg::*;

  localparam int    UP_SHIFT   = WORK_FRAC - FRAC_BITS_DEF;
  localparam work_t WORK_MAX   = '1;

  typedef struct packed {
    sinh_t sinh_value;
    cosh_t cosh_value;
  } sinh_cosh_t;

  tol_t       tolerance;
  sinh_cosh_t expected_sinh_cosh_q[$];

  function automatic work_t mul_trunc(work_t a, work_t b);
    logic [PROD_W-1:0] p;
    p = (PROD_W'(a) * PROD_W'(b)) >> WORK_FRAC;
    return (p > PROD_W'(WORK_MAX)) ? WORK_MAX : p[WORK_W-1:0];
  endfunction

  function automatic work_t add_clip(work_t a, work_t b);
    logic [WORK_W:0] r;
    r = {1'b0, a} + {1'b0, b};
    return (r > {1'b0, WORK_MAX}) ? WORK_MAX : r[WORK_W-1:0];
  endfunction

  function automatic cosh_t round_out(work_t v);
    work_t r;
    r = (v >> UP_SHIFT) + ((v >> (UP_SHIFT - 1)) & work_t'(1));
    return (r > work_t'({COSH_W{1'b1}})) ? '1 : r[COSH_W-1:0];
  endfunction

  function automatic sinh_cosh_t predict_sinh_cosh(angle_t angle, tol_t tol);
    logic [ANGLE_W-1:0] raw;
    logic               neg;
    work_t              mag, y, y2, y3, s, c, t, u;
    int                 k;
    cosh_t              s_out;
    sinh_cosh_t         r;
    raw = angle;
    neg = raw[ANGLE_W-1];
    mag = neg ? (work_t'(1) << ANGLE_W) - work_t'(raw) : work_t'(raw);
    k = 0;
    while (k < MAX_HALVINGS_DEF && !((mag >> k) < work_t'(tol)))
      k++;
    y  = (mag << UP_SHIFT) >> k;
    y2 = mul_trunc(y, y);
    y3 = mul_trunc(y2, y);
    s  = add_clip(y, y3 / 6);
    c  = add_clip(WORK_ONE, y2 >> 1);
    for (int i = 0; i < k; i++) begin
      t = mul_trunc(s, c);
      u = mul_trunc(s, s);
      s = add_clip(t, t);
      c = add_clip(WORK_ONE, add_clip(u, u));
    end
    s_out = round_out(s);
    r.sinh_value = neg ? sinh_t'(SINH_W'(0) - {1'b0, s_out}) : sinh_t'({1'b0, s_out});
    r.cosh_value = round_out(c);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sinh_cosh_t want;
    if (!rst_ni) begin
      tolerance    <= TOL_RESET;
      pending_o    <= 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) tolerance <= cfg_wdata_i;
      if (in_mon_i.valid && in_mon_i.ready)
        expected_sinh_cosh_q.push_back(predict_sinh_cosh(in_mon_i.angle, tolerance));
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_sinh_cosh_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_mon_i.sinh_value), 64'd0);
        end else begin
          want = expected_sinh_cosh_q.pop_front();
          if (out_mon_i.sinh_value !== want.sinh_value)
            report_mismatch("sinh_value", 64'(out_mon_i.sinh_value), 64'(want.sinh_value));
          if (out_mon_i.cosh_value !== want.cosh_value)
            report_mismatch("cosh_value", 64'(out_mon_i.cosh_value), 64'(want.cosh_value));
        end
      end
      pending_o <= expected_sinh_cosh_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: tb/sinh_cosh_by_angle_doubling_tb.sv
// top of the sinh/cosh testbench: clock, reset, angle requests, result back-pressure,
// tolerance settings, watchdog and verdict
// depends on sccad_pkg, sccad_if, sinh_cosh_checker and the block itself
`default_nettype none

module sinh_cosh_by_angle_doubling_tb;
  import sccad_pkg::*;

  localparam int N_CORNERS      = 19;
  localparam int N_PHASES       = 7;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  tol_t cfg_wdata;
  bit   idle_on;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;

  sccad_in_if  in_ch ();
  sccad_out_if out_ch ();

  sinh_cosh_by_angle_doubling DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  sinh_cosh_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // tolerance boundaries, unit values, full scale and the lone out-of-range pattern
  angle_t corner_angles [N_CORNERS] = '{
    angle_t'(0), angle_t'(1), angle_t'(-1), angle_t'(267), angle_t'(268),
    angle_t'(269), angle_t'(535), angle_t'(536), angle_t'(-268),
    angle_t'(268435456), angle_t'(-268435456), angle_t'(536870912),
    angle_t'(1073741823), angle_t'(-1073741823), angle_t'(31'h4000_0000),
    angle_t'(31'h2AAA_AAAA), angle_t'(31'h5555_5555),
    angle_t'(805306368), angle_t'(-805306368)
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic send_angle(input angle_t a);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.angle <= a;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_tolerance(input tol_t value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // result side back-pressure in bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0)
        stall_left--;
      else if (idle_on && $urandom_range(0, 11) == 0)
        stall_left = $urandom_range(1, 8);
      out_ch.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    tol_t   phase_tol [N_PHASES];
    angle_t a;
    int     pick;
    phase_tol = '{tol_t'(1), tol_t'(0), tol_t'(268435456), '1,
                  tol_t'($urandom_range(1, 268435456)), tol_t'($urandom_range(2, 4096)),
                  TOL_RESET};
    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= TOL_RESET;
    in_ch.valid  <= 1'b0;
    in_ch.angle  <= '0;
    idle_on      = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_angles[i]) send_angle(corner_angles[i]);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      write_tolerance(phase_tol[ph]);
      idle_on = (ph != N_PHASES - 1) && (ph != 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          a = corner_angles[$urandom_range(0, N_CORNERS - 1)];
        end else if (pick < 4) begin
          a = angle_t'($urandom() >> $urandom_range(1, 31));
          if ($urandom_range(0, 1) == 1) a = -a;
        end else begin
          a = angle_t'($urandom());
        end
        send_angle(a);
      end
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
